/* rtl/vcfb_pkg.sv */
// ----------------------------------------------------------------------------
// vcfb_pkg
// Shared types and constants for the virtual channel flit buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package vcfb_pkg;

    // Fixed field widths of the ports
    localparam int KIND_W    = 2;
    localparam int CHAN_W    = 3;
    localparam int DATA_W    = 64;
    localparam int OCC_W     = 5;
    localparam int ERR_W     = 2;
    localparam int CIU_W     = 4;
    localparam int DL_W      = 5;
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;

    // Register reset values
    localparam logic [CIU_W-1:0] CIU_RESET = 4'd8;
    localparam logic [DL_W-1:0]  DL_RESET  = 5'd16;

    // Operation codes
    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH   = 2'd0,
        KIND_PULL   = 2'd1,
        KIND_PEEK   = 2'd2,
        KIND_STATUS = 2'd3
    } kind_t;

    // Result error codes
    typedef enum logic [ERR_W-1:0] {
        ERR_OK      = 2'd0,
        ERR_CHANNEL = 2'd1,
        ERR_EMPTY   = 2'd2,
        ERR_FULL    = 2'd3
    } err_t;

    // Register word index (paddr[2])
    typedef enum logic {
        REG_CHANNELS_IN_USE = 1'b0,
        REG_DEPTH_LIMIT     = 1'b1
    } reg_idx_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_META = 2'd1,
        ST_FLIT = 2'd2
    } state_t;

    // Configuration seen by the datapath
    typedef struct packed {
        logic [CIU_W-1:0] channels_in_use;
        logic [DL_W-1:0]  depth_limit;
        logic             clear;
    } cfg_t;

endpackage

`default_nettype wire

/* rtl/vcfb_ram.sv */
// ----------------------------------------------------------------------------
// vcfb_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module vcfb_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 128,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write, and register the read word
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

/* rtl/vcfb_cfg.sv */
// ----------------------------------------------------------------------------
// vcfb_cfg
// APB register file: channel count and depth limit; a write clears the FIFOs.
// ----------------------------------------------------------------------------
`default_nettype none

module vcfb_cfg (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [vcfb_pkg::APB_AW-1:0]   paddr,
    input  wire logic [vcfb_pkg::APB_DW-1:0]   pwdata,
    output logic      [vcfb_pkg::APB_DW-1:0]   prdata,
    output logic                               pready,
    output vcfb_pkg::cfg_t                     cfg
);

    logic [vcfb_pkg::CIU_W-1:0] ciu_reg;
    logic [vcfb_pkg::CIU_W-1:0] ciu_next;
    logic [vcfb_pkg::DL_W-1:0]  dl_reg;
    logic [vcfb_pkg::DL_W-1:0]  dl_next;
    logic                       wr_strobe;
    vcfb_pkg::reg_idx_t         reg_idx;

    assign pready    = 1'b1;
    assign wr_strobe = psel && penable && pwrite && pready;
    assign reg_idx   = vcfb_pkg::reg_idx_t'(paddr[2]);

    // Decode the write
    always_comb begin
        ciu_next = ciu_reg;
        dl_next  = dl_reg;
        if (wr_strobe) begin
            case (reg_idx)
                vcfb_pkg::REG_CHANNELS_IN_USE: ciu_next = pwdata[vcfb_pkg::CIU_W-1:0];
                vcfb_pkg::REG_DEPTH_LIMIT:     dl_next  = pwdata[vcfb_pkg::DL_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ciu_reg <= vcfb_pkg::CIU_RESET;
            dl_reg  <= vcfb_pkg::DL_RESET;
        end else begin
            ciu_reg <= ciu_next;
            dl_reg  <= dl_next;
        end
    end

    // Read back
    always_comb begin
        case (reg_idx)
            vcfb_pkg::REG_CHANNELS_IN_USE:
                prdata = {{(vcfb_pkg::APB_DW-vcfb_pkg::CIU_W){1'b0}}, ciu_reg};
            vcfb_pkg::REG_DEPTH_LIMIT:
                prdata = {{(vcfb_pkg::APB_DW-vcfb_pkg::DL_W){1'b0}}, dl_reg};
            default:
                prdata = '0;
        endcase
    end

    // Any register write empties every FIFO
    assign cfg.channels_in_use = ciu_reg;
    assign cfg.depth_limit     = dl_reg;
    assign cfg.clear           = wr_strobe;

endmodule

`default_nettype wire

/* rtl/virtual_channel_flit_buffer_core.sv */
// ----------------------------------------------------------------------------
// virtual_channel_flit_buffer_core
// Router input buffer with one flit FIFO per virtual channel. Per-channel
// pointers and counts live in a small state RAM, flits in a flit RAM.
// ----------------------------------------------------------------------------
//  Channel   Ports        Direction  Moves
//  config    p*           in/out     APB register write/read
//  request   s_*          in         kind, channel, flit_data
//  result    m_*          out        head_data, occupancy, flags, error_code
//
//  An item passes through accept (state RAM read issued), state update
//  (write-back and flit RAM access) and result load into the output register.
//  The next item is accepted only after the state write-back, so the state RAM
//  never sees a read and a write of the same entry together.
//  A result waiting on m_ready holds the sequencer in its result load step.
//  Reset is synchronous, active low; per-channel valid bits empty every FIFO
//  at once on reset or on a register write, no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module virtual_channel_flit_buffer_core #(
    parameter int MAX_CHANNELS = 8,
    parameter int MAX_DEPTH    = 16,
    parameter int FLIT_BITS    = 64
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // configuration
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [vcfb_pkg::APB_AW-1:0]   paddr,
    input  wire logic [vcfb_pkg::APB_DW-1:0]   pwdata,
    output logic      [vcfb_pkg::APB_DW-1:0]   prdata,
    output logic                               pready,
    // request
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [vcfb_pkg::KIND_W-1:0]   s_kind,
    input  wire logic [vcfb_pkg::CHAN_W-1:0]   s_channel,
    input  wire logic [vcfb_pkg::DATA_W-1:0]   s_flit_data,
    // result
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic      [vcfb_pkg::DATA_W-1:0]   m_head_data,
    output logic      [vcfb_pkg::OCC_W-1:0]    m_occupancy,
    output logic                               m_is_empty_flag,
    output logic                               m_is_full_flag,
    output logic      [vcfb_pkg::ERR_W-1:0]    m_error_code
);

    localparam int CHW        = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int PW         = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int FLIT_DEPTH = MAX_CHANNELS * MAX_DEPTH;
    localparam int FAW        = (FLIT_DEPTH > 1) ? $clog2(FLIT_DEPTH) : 1;
    localparam int OW         = vcfb_pkg::OCC_W;
    localparam int MW         = 2 * PW + OW;

    vcfb_pkg::cfg_t   cfg;

    vcfb_pkg::state_t state_reg;
    vcfb_pkg::state_t state_next;

    // Captured request
    vcfb_pkg::kind_t              kind_reg;
    logic [vcfb_pkg::CHAN_W-1:0]  ch_reg;
    logic [FLIT_BITS-1:0]         data_reg;

    // Per-channel state
    logic [MAX_CHANNELS-1:0]      meta_valid_reg;
    logic [MAX_CHANNELS-1:0]      meta_valid_next;
    logic [MW-1:0]                meta_rd_data;
    logic [MW-1:0]                meta_wr_data;
    logic                         meta_rd_en;
    logic                         meta_wr_en;

    // Flit store
    logic [FAW-1:0]               flit_wr_addr;
    logic [FAW-1:0]               flit_rd_addr;
    logic [FLIT_BITS-1:0]         flit_rd_data;
    logic                         flit_wr_en;
    logic                         flit_rd_en;

    // Update logic
    logic [CHW-1:0]               ch_idx;
    logic                         ch_ok;
    logic [OW-1:0]                limit;
    logic [PW-1:0]                head_ptr;
    logic [PW-1:0]                tail_ptr;
    logic [OW-1:0]                cnt;
    logic [PW-1:0]                head_new;
    logic [PW-1:0]                tail_new;
    logic [OW-1:0]                cnt_new;
    logic                         do_push;
    logic                         do_read;
    vcfb_pkg::err_t               err_calc;

    // Result held between update and output load
    logic [OW-1:0]                occ_reg;
    logic                         empty_reg;
    logic                         full_reg;
    vcfb_pkg::err_t               err_reg;
    logic                         hit_reg;

    // Output register
    logic                         out_load;
    logic                         m_valid_reg;
    logic                         m_valid_next;
    logic [vcfb_pkg::DATA_W-1:0]  m_head_data_reg;
    logic [OW-1:0]                m_occ_reg;
    logic                         m_empty_reg;
    logic                         m_full_reg;
    logic [vcfb_pkg::ERR_W-1:0]   m_err_reg;

    vcfb_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    vcfb_ram #(
        .WIDTH (MW),
        .DEPTH (MAX_CHANNELS)
    ) u_meta_ram (
        .aclk    (aclk),
        .wr_en   (meta_wr_en),
        .wr_addr (ch_idx),
        .wr_data (meta_wr_data),
        .rd_en   (meta_rd_en),
        .rd_addr (CHW'(s_channel)),
        .rd_data (meta_rd_data)
    );

    vcfb_ram #(
        .WIDTH (FLIT_BITS),
        .DEPTH (FLIT_DEPTH)
    ) u_flit_ram (
        .aclk    (aclk),
        .wr_en   (flit_wr_en),
        .wr_addr (flit_wr_addr),
        .wr_data (data_reg),
        .rd_en   (flit_rd_en),
        .rd_addr (flit_rd_addr),
        .rd_data (flit_rd_data)
    );

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            vcfb_pkg::ST_IDLE: if (s_valid) state_next = vcfb_pkg::ST_META;
            vcfb_pkg::ST_META: state_next = vcfb_pkg::ST_FLIT;
            vcfb_pkg::ST_FLIT: if (!m_valid_reg || m_ready) state_next = vcfb_pkg::ST_IDLE;
            default:           state_next = vcfb_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        s_ready    = 1'b0;
        meta_rd_en = 1'b0;
        meta_wr_en = 1'b0;
        flit_wr_en = 1'b0;
        flit_rd_en = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            vcfb_pkg::ST_IDLE: begin
                s_ready    = 1'b1;
                meta_rd_en = s_valid;
            end
            vcfb_pkg::ST_META: begin
                meta_wr_en = ch_ok;
                flit_wr_en = do_push;
                flit_rd_en = do_read;
            end
            vcfb_pkg::ST_FLIT: begin
                out_load = !m_valid_reg || m_ready;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= vcfb_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Capture the request on transfer
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            kind_reg <= vcfb_pkg::kind_t'(s_kind);
            ch_reg   <= s_channel;
            data_reg <= s_flit_data[FLIT_BITS-1:0];
        end
    end

    // Decode channel state and work out the update
    always_comb begin
        ch_idx = CHW'(ch_reg);
        ch_ok  = (32'(ch_reg) < 32'(cfg.channels_in_use)) && (32'(ch_reg) < MAX_CHANNELS);
        limit  = (32'(cfg.depth_limit) > MAX_DEPTH) ? OW'(MAX_DEPTH) : cfg.depth_limit;
        if (meta_valid_reg[ch_idx]) begin
            {head_ptr, tail_ptr, cnt} = meta_rd_data;
        end else begin
            head_ptr = '0;
            tail_ptr = '0;
            cnt      = '0;
        end
        head_new = head_ptr;
        tail_new = tail_ptr;
        cnt_new  = cnt;
        do_push  = 1'b0;
        do_read  = 1'b0;
        err_calc = vcfb_pkg::ERR_OK;
        if (!ch_ok) begin
            err_calc = vcfb_pkg::ERR_CHANNEL;
        end else begin
            case (kind_reg)
                vcfb_pkg::KIND_PUSH: begin
                    if (cnt >= limit) begin
                        err_calc = vcfb_pkg::ERR_FULL;
                    end else begin
                        do_push  = 1'b1;
                        tail_new = (tail_ptr == PW'(MAX_DEPTH - 1)) ? '0 : PW'(tail_ptr + 1'b1);
                        cnt_new  = OW'(cnt + 1'b1);
                    end
                end
                vcfb_pkg::KIND_PULL, vcfb_pkg::KIND_PEEK: begin
                    if (cnt == '0) begin
                        err_calc = vcfb_pkg::ERR_EMPTY;
                    end else begin
                        do_read = 1'b1;
                        if (kind_reg == vcfb_pkg::KIND_PULL) begin
                            head_new = (head_ptr == PW'(MAX_DEPTH - 1)) ? '0
                                                                        : PW'(head_ptr + 1'b1);
                            cnt_new  = OW'(cnt - 1'b1);
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign meta_wr_data = {head_new, tail_new, cnt_new};
    assign flit_wr_addr = FAW'(int'(ch_idx) * MAX_DEPTH + int'(tail_ptr));
    assign flit_rd_addr = FAW'(int'(ch_idx) * MAX_DEPTH + int'(head_ptr));

    // Mark written channels; drop all on reset or register write
    always_comb begin
        meta_valid_next = meta_valid_reg;
        if (cfg.clear) begin
            meta_valid_next = '0;
        end else if (meta_wr_en) begin
            meta_valid_next[ch_idx] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            meta_valid_reg <= '0;
        end else begin
            meta_valid_reg <= meta_valid_next;
        end
    end

    // Hold the status while the flit RAM read completes
    always_ff @(posedge aclk) begin
        if (state_reg == vcfb_pkg::ST_META) begin
            occ_reg   <= ch_ok ? cnt_new : '0;
            empty_reg <= ch_ok && (cnt_new == '0);
            full_reg  <= ch_ok && (cnt_new == limit);
            err_reg   <= err_calc;
            hit_reg   <= do_read;
        end
    end

    // Output register
    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_head_data_reg <= hit_reg ? vcfb_pkg::DATA_W'(flit_rd_data) : '0;
            m_occ_reg       <= occ_reg;
            m_empty_reg     <= empty_reg;
            m_full_reg      <= full_reg;
            m_err_reg       <= err_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_head_data     = m_head_data_reg;
    assign m_occupancy     = m_occ_reg;
    assign m_is_empty_flag = m_empty_reg;
    assign m_is_full_flag  = m_full_reg;
    assign m_error_code    = m_err_reg;

endmodule

`default_nettype wire

/* rtl/vcfb_checker.sv */
// ----------------------------------------------------------------------------
// vcfb_checker
// Port-level checks on the flit buffer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module vcfb_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_valid,
    input wire logic                          s_ready,
    input wire logic                          m_valid,
    input wire logic                          m_ready,
    input wire logic [vcfb_pkg::DATA_W-1:0]   m_head_data,
    input wire logic [vcfb_pkg::OCC_W-1:0]    m_occupancy,
    input wire logic                          m_is_empty_flag,
    input wire logic                          m_is_full_flag,
    input wire logic [vcfb_pkg::ERR_W-1:0]    m_error_code
);

    // Result stays offered until taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped before transfer");

    // One item at a time: no request taken right after a transfer
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request accepted while previous item in work");

    // Bad channel reports nothing else
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_error_code == vcfb_pkg::ERR_CHANNEL) |->
            (m_head_data == '0) && (m_occupancy == '0) &&
            !m_is_empty_flag && !m_is_full_flag)
        else $error("channel error with nonzero status");

    // Empty flag tracks occupancy
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_error_code != vcfb_pkg::ERR_CHANNEL) |->
            (m_is_empty_flag == (m_occupancy == '0)))
        else $error("empty flag disagrees with occupancy");

endmodule

bind virtual_channel_flit_buffer_core vcfb_checker u_vcfb_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_head_data     (m_head_data),
    .m_occupancy     (m_occupancy),
    .m_is_empty_flag (m_is_empty_flag),
    .m_is_full_flag  (m_is_full_flag),
    .m_error_code    (m_error_code)
);

`default_nettype wire

/* verif/vcfb_flit_checker.sv */
// ----------------------------------------------------------------------------
// vcfb_flit_checker
// Watches the config, request and result ports of the flit buffer. Keeps a
// mirror of every virtual channel FIFO, computes the result of each accepted
// request and compares it, in order, against the results the block returns.
// ----------------------------------------------------------------------------
module vcfb_flit_checker
    import vcfb_pkg::*;
#(
    parameter int MAX_CHANNELS = 8,
    parameter int MAX_DEPTH    = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic              pready,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    input  logic              s_valid,
    input  logic              s_ready,
    input  logic [KIND_W-1:0] s_kind,
    input  logic [CHAN_W-1:0] s_channel,
    input  logic [DATA_W-1:0] s_flit_data,
    input  logic              m_valid,
    input  logic              m_ready,
    input  logic [DATA_W-1:0] m_head_data,
    input  logic [OCC_W-1:0]  m_occupancy,
    input  logic              m_is_empty_flag,
    input  logic              m_is_full_flag,
    input  logic [ERR_W-1:0]  m_error_code,
    output int                mismatch_count,
    output int                pending_results
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [DATA_W-1:0] head_data;
        logic [OCC_W-1:0]  occupancy;
        logic              empty_flag;
        logic              full_flag;
        err_t              error_code;
    } flit_result_t;

    // Mirror of the configuration and of each channel's ring
    logic [CIU_W-1:0]  mirror_channels;
    logic [DL_W-1:0]   mirror_depth;
    logic [DATA_W-1:0] vc_slots [MAX_CHANNELS][MAX_DEPTH];
    int unsigned       vc_head  [MAX_CHANNELS];
    int unsigned       vc_fill  [MAX_CHANNELS];

    flit_result_t      expected_results [$];
    int                result_index;

    // Empty every mirrored FIFO, as a register write or reset does
    task automatic flush_channels();
        for (int i = 0; i < MAX_CHANNELS; i++) begin
            vc_head[i] = 0;
            vc_fill[i] = 0;
        end
    endtask

    // Apply one request to the mirror and return the result it should give
    function automatic flit_result_t apply_flit_op(kind_t op, logic [CHAN_W-1:0] vc,
                                                   logic [DATA_W-1:0] data);
        flit_result_t res;
        int unsigned  active_channels;
        int unsigned  fill_limit;
        res = '0;
        active_channels = (mirror_channels > MAX_CHANNELS) ? MAX_CHANNELS : mirror_channels;
        fill_limit      = (mirror_depth > MAX_DEPTH) ? MAX_DEPTH : mirror_depth;
        // Out-of-range channel: drop, all fields zero but the code
        if (vc >= active_channels) begin
            res.error_code = ERR_CHANNEL;
            return res;
        end
        res.error_code = ERR_OK;
        case (op)
            KIND_PUSH: begin
                if (vc_fill[vc] >= fill_limit) begin
                    res.error_code = ERR_FULL;
                end else begin
                    vc_slots[vc][(vc_head[vc] + vc_fill[vc]) % MAX_DEPTH] = data;
                    vc_fill[vc]++;
                end
            end
            KIND_PULL, KIND_PEEK: begin
                if (vc_fill[vc] == 0) begin
                    res.error_code = ERR_EMPTY;
                end else begin
                    res.head_data = vc_slots[vc][vc_head[vc]];
                    if (op == KIND_PULL) begin
                        vc_head[vc] = (vc_head[vc] + 1) % MAX_DEPTH;
                        vc_fill[vc]--;
                    end
                end
            end
            default: ;
        endcase
        res.occupancy  = OCC_W'(vc_fill[vc]);
        res.empty_flag = (vc_fill[vc] == 0);
        res.full_flag  = (vc_fill[vc] == fill_limit);
        return res;
    endfunction

    // Print one line per mismatch and count it
    task automatic report_mismatch(string field, logic [DATA_W-1:0] got,
                                   logic [DATA_W-1:0] want);
        $display("result %0d: %s mismatch, got %0h expected %0h",
                 result_index, field, got, want);
        mismatch_count++;
    endtask

    // Compare one returned result against the oldest expectation
    task automatic check_result();
        flit_result_t want;
        if (expected_results.size() == 0) begin
            report_mismatch("unexpected result", m_head_data, '0);
            return;
        end
        want = expected_results[0];
        expected_results.delete(0);
        if (m_head_data !== want.head_data)
            report_mismatch("head_data", m_head_data, want.head_data);
        if (m_occupancy !== want.occupancy)
            report_mismatch("occupancy", m_occupancy, want.occupancy);
        if (m_is_empty_flag !== want.empty_flag)
            report_mismatch("is_empty_flag", m_is_empty_flag, want.empty_flag);
        if (m_is_full_flag !== want.full_flag)
            report_mismatch("is_full_flag", m_is_full_flag, want.full_flag);
        if (m_error_code !== want.error_code)
            report_mismatch("error_code", m_error_code, want.error_code);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            mirror_channels = CIU_RESET;
            mirror_depth    = DL_RESET;
            flush_channels();
            expected_results.delete();
            result_index    = 0;
            pending_results <= 0;
        end else begin
            // Track register writes; either register empties all FIFOs
            if (psel && penable && pwrite && pready) begin
                if (reg_idx_t'(paddr[2]) == REG_CHANNELS_IN_USE)
                    mirror_channels = pwdata[CIU_W-1:0];
                else
                    mirror_depth = pwdata[DL_W-1:0];
                flush_channels();
            end
            // Check each result transfer
            if (m_valid && m_ready) begin
                check_result();
                result_index++;
            end
            // Predict each request transfer
            if (s_valid && s_ready)
                expected_results.insert(expected_results.size(),
                                        apply_flit_op(kind_t'(s_kind), s_channel,
                                                      s_flit_data));
            pending_results <= expected_results.size();
        end
    end

endmodule

/* verif/tb_virtual_channel_flit_buffer_core.sv */
// ----------------------------------------------------------------------------
// tb_virtual_channel_flit_buffer_core
// Drives the flit buffer with a directed sequence of pushes, pulls, peeks and
// status requests, then with random traffic over several channel and depth
// settings, with random idle cycles on both sides. The checker beside the
// block predicts and compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_virtual_channel_flit_buffer_core;
    import vcfb_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASES      = 9;

    logic              aclk        = 1'b0;
    logic              aresetn     = 1'b0;
    logic              psel        = 1'b0;
    logic              penable     = 1'b0;
    logic              pwrite      = 1'b0;
    logic [APB_AW-1:0] paddr       = '0;
    logic [APB_DW-1:0] pwdata      = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;
    logic              s_valid     = 1'b0;
    logic              s_ready;
    logic [KIND_W-1:0] s_kind      = '0;
    logic [CHAN_W-1:0] s_channel   = '0;
    logic [DATA_W-1:0] s_flit_data = '0;
    logic              m_valid;
    logic              m_ready     = 1'b0;
    logic [DATA_W-1:0] m_head_data;
    logic [OCC_W-1:0]  m_occupancy;
    logic              m_is_empty_flag;
    logic              m_is_full_flag;
    logic [ERR_W-1:0]  m_error_code;

    int                mismatch_count;
    int                pending_results;
    int                cycle_count = 0;
    logic              steady_flow = 1'b0;

    // Per-phase settings: extremes, capped values and zero among them
    int phase_channels [PHASES] = '{8, 1, 15, 3, 0, 8, 5, 2, 8};
    int phase_depth    [PHASES] = '{16, 1, 31, 4, 16, 0, 2, 7, 16};
    int phase_items    [PHASES] = '{200, 150, 180, 200, 40, 40, 180, 180, 200};

    virtual_channel_flit_buffer_core dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_kind          (s_kind),
        .s_channel       (s_channel),
        .s_flit_data     (s_flit_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_head_data     (m_head_data),
        .m_occupancy     (m_occupancy),
        .m_is_empty_flag (m_is_empty_flag),
        .m_is_full_flag  (m_is_full_flag),
        .m_error_code    (m_error_code)
    );

    vcfb_flit_checker checker_i (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .pready          (pready),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_kind          (s_kind),
        .s_channel       (s_channel),
        .s_flit_data     (s_flit_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_head_data     (m_head_data),
        .m_occupancy     (m_occupancy),
        .m_is_empty_flag (m_is_empty_flag),
        .m_is_full_flag  (m_is_full_flag),
        .m_error_code    (m_error_code),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Stall the result side about 6 percent of the time, never during steady flow
    always @(posedge aclk) begin
        m_ready <= steady_flow || ($urandom_range(0, 99) >= 6);
    end

    // Guard against a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results);
            $display("== FAIL ==");
            $finish;
        end
    end

    // Offer one request and hold it until the transfer
    task automatic send_flit_op(kind_t op, logic [CHAN_W-1:0] vc, logic [DATA_W-1:0] data);
        while (!steady_flow && $urandom_range(0, 99) < 6) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_kind      <= op;
        s_channel   <= vc;
        s_flit_data <= data;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Drop valid and hold until every outstanding result has come back
    task automatic wait_results_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_results != 0);
    endtask

    // Write one register while idle; bits above the field get random values
    task automatic write_config_reg(reg_idx_t idx, int unsigned value);
        logic [APB_DW-1:0] field_mask;
        wait_results_drained();
        field_mask = (idx == REG_CHANNELS_IN_USE) ? 32'h0000_000F : 32'h0000_001F;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= (value & field_mask) | ($urandom & ~field_mask);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // One random request: mostly on active channels, push share set by caller
    task automatic send_random_op(int push_pct, int vc_span);
        int                roll;
        int                rest;
        kind_t             op;
        logic [CHAN_W-1:0] vc;
        logic [DATA_W-1:0] data;
        roll = $urandom_range(0, 99);
        rest = (roll - push_pct) * 100 / (100 - push_pct);
        if (roll < push_pct)
            op = KIND_PUSH;
        else if (rest < 60)
            op = KIND_PULL;
        else if (rest < 85)
            op = KIND_PEEK;
        else
            op = KIND_STATUS;
        if ($urandom_range(0, 99) < 92)
            vc = $urandom_range(0, vc_span - 1);
        else
            vc = $urandom_range(0, 7);
        roll = $urandom_range(0, 99);
        if (roll < 8)
            data = '1;
        else if (roll < 12)
            data = '0;
        else
            data = {$urandom, $urandom};
        send_flit_op(op, vc, data);
    endtask

    initial begin
        int vc_span;
        int push_pct;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Basic order, peek versus pull, empty pulls and status at reset setting
        send_flit_op(KIND_PUSH, 3'd0, 64'hFFFF_FFFF_FFFF_FFFF);
        send_flit_op(KIND_PUSH, 3'd0, 64'h0);
        send_flit_op(KIND_PEEK, 3'd0, 64'h1234_5678_9ABC_DEF0);
        send_flit_op(KIND_PULL, 3'd0, 64'h0);
        send_flit_op(KIND_PULL, 3'd0, 64'h0);
        send_flit_op(KIND_PULL, 3'd0, 64'h0);
        send_flit_op(KIND_PEEK, 3'd0, 64'h0);
        send_flit_op(KIND_STATUS, 3'd7, 64'hFFFF_FFFF_FFFF_FFFF);
        send_flit_op(KIND_PUSH, 3'd7, 64'h5555_AAAA_5555_AAAA);
        send_flit_op(KIND_STATUS, 3'd7, 64'h0);
        send_flit_op(KIND_PULL, 3'd7, 64'h0);

        // Depth of one: push to a full channel
        write_config_reg(REG_DEPTH_LIMIT, 1);
        send_flit_op(KIND_PUSH, 3'd2, 64'hAAAA_5555_AAAA_5555);
        send_flit_op(KIND_PUSH, 3'd2, 64'h0123_4567_89AB_CDEF);
        send_flit_op(KIND_STATUS, 3'd2, 64'h0);
        send_flit_op(KIND_PEEK, 3'd2, 64'h0);
        send_flit_op(KIND_PULL, 3'd2, 64'h0);

        // Channel out of range, then a count of zero rejecting everything
        write_config_reg(REG_CHANNELS_IN_USE, 1);
        send_flit_op(KIND_PUSH, 3'd1, 64'hDEAD_BEEF_DEAD_BEEF);
        send_flit_op(KIND_PUSH, 3'd0, 64'hDEAD_BEEF_DEAD_BEEF);
        send_flit_op(KIND_STATUS, 3'd7, 64'h0);
        write_config_reg(REG_CHANNELS_IN_USE, 0);
        send_flit_op(KIND_STATUS, 3'd0, 64'h0);

        // Capped channel count, depth of zero reports full and empty together
        write_config_reg(REG_CHANNELS_IN_USE, 15);
        write_config_reg(REG_DEPTH_LIMIT, 0);
        send_flit_op(KIND_PUSH, 3'd7, 64'hFFFF_0000_FFFF_0000);
        send_flit_op(KIND_STATUS, 3'd7, 64'h0);
        send_flit_op(KIND_PULL, 3'd7, 64'h0);

        // Capped depth
        write_config_reg(REG_DEPTH_LIMIT, 31);
        send_flit_op(KIND_PUSH, 3'd6, 64'h0F0F_0F0F_0F0F_0F0F);
        send_flit_op(KIND_PULL, 3'd6, 64'h0);

        // Random traffic, one setting per phase
        for (int ph = 0; ph < PHASES; ph++) begin
            write_config_reg(REG_CHANNELS_IN_USE, phase_channels[ph]);
            write_config_reg(REG_DEPTH_LIMIT, phase_depth[ph]);
            vc_span = (phase_channels[ph] > 8) ? 8 : phase_channels[ph];
            if (vc_span == 0)
                vc_span = 8;
            steady_flow <= (ph == 3);
            push_pct = 50;
            for (int n = 0; n < phase_items[ph]; n++) begin
                // Swing the push share so channels fill up and drain again
                if (n % 40 == 0)
                    push_pct = $urandom_range(25, 75);
                if ((ph == 1 && n == 60) || $urandom_range(0, 149) == 0)
                    wait_results_drained();
                send_random_op(push_pct, vc_span);
            end
        end
        steady_flow <= 1'b0;

        wait_results_drained();
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/vcfb_pkg.sv
rtl/vcfb_ram.sv
rtl/vcfb_cfg.sv
rtl/virtual_channel_flit_buffer_core.sv
rtl/vcfb_checker.sv
verif/vcfb_flit_checker.sv
verif/tb_virtual_channel_flit_buffer_core.sv
